// File: src/assert_macros.svh
// assertion macros used by the decoder core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: src/ilbm_pkg.sv
// shared constants for the ilbm body decoder
`timescale 1ns / 1ps
`default_nettype none

package ilbm_pkg;

    localparam int CFG_DATA_W   = 11;
    localparam int CFG_INDEX_W  = 2;
    localparam int BYTE_W       = 8;
    localparam int PIXELS_W     = 64;
    localparam int COLUMN_W     = 6;
    localparam int ROW_OUT_W    = 10;
    localparam int ROW_CNT_W    = 11;
    localparam int ROW_BYTES_W  = 6;
    localparam int PLANE_CNT_W  = 4;
    localparam int LEFT_W       = 8;
    localparam int ROW_LIMIT    = 1024;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_COMPRESSED  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_BYTES   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_COUNT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT   = 2'd3;

    // configuration reset values
    localparam logic                   RST_COMPRESSED  = 1'b1;
    localparam logic [ROW_BYTES_W-1:0] RST_ROW_BYTES   = 6'd40;
    localparam logic [PLANE_CNT_W-1:0] RST_PLANE_COUNT = 4'd8;
    localparam logic [ROW_CNT_W-1:0]   RST_ROW_COUNT   = 11'd200;

    // byterun1 command codes
    localparam logic [BYTE_W-1:0] CMD_NOOP     = 8'h80;
    localparam logic [8:0]        RUN_BIAS     = 9'd257;

endpackage

`default_nettype wire

// File: src/ilbm_body_decoder_core.sv
// ilbm body decoder: byterun1 or raw bit-plane rows to chunky pixel groups
//
//  channel   direction  handshake             payload
//  cfg       in         cfg_write             cfg_index, cfg_data
//  in        in         in_valid / in_ready   data_byte
//  out       out        out_valid / out_ready pixels, column, row_index_out,
//                                             last_of_burst, row_end, image_end
//
// command and skipped bytes are taken in idle; a raw or literal byte is taken, then
// written in the put step; a run's byte is written once per repeat (fewer if the line
//   ends first), one read-modify-write of the line buffer per repeated byte
// a byte on the last plane waits in the write step while the output register is full
// reset clears control state and the line buffer valid bits, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ilbm_body_decoder_core #(
    parameter int MAX_ROW_BYTES = 40,
    parameter int MAX_PLANES    = 8,
    parameter int MAX_ROWS      = 1024
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [ilbm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [ilbm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [ilbm_pkg::BYTE_W-1:0]         data_byte,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [ilbm_pkg::PIXELS_W-1:0]            pixels,
    output logic [ilbm_pkg::COLUMN_W-1:0]            column,
    output logic [ilbm_pkg::ROW_OUT_W-1:0]           row_index_out,
    output logic                                     last_of_burst,
    output logic                                     row_end,
    output logic                                     image_end
);
    import ilbm_pkg::*;

    localparam int COL_W    = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int PLANE_W  = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int BUF_W    = BYTE_W * MAX_PLANES;
    localparam int RB_W     = ROW_BYTES_W + 1;
    localparam int ROW_CAP  = (MAX_ROWS < ROW_LIMIT) ? MAX_ROWS : ROW_LIMIT;

    typedef enum logic {S_IDLE, S_PUT} state_t;
    typedef enum logic [1:0] {PH_CMD, PH_LIT, PH_RUN, PH_SKIP} phase_t;
    typedef enum logic [1:0] {M_ONE, M_LIT, M_RUN} mode_t;

    state_t                    state_reg, state_next;
    phase_t                    phase_reg, phase_next;
    mode_t                     mode_reg, mode_next;
    logic [LEFT_W-1:0]         bytes_left_reg, bytes_left_next;
    logic [BYTE_W-1:0]         put_byte_reg, put_byte_next;
    logic [COL_W-1:0]          column_pos_reg, column_pos_next;
    logic [PLANE_W-1:0]        plane_pos_reg, plane_pos_next;
    logic [ROW_OUT_W-1:0]      row_pos_reg, row_pos_next;

    logic                      compressed_reg, compressed_next;
    logic [ROW_BYTES_W-1:0]    row_bytes_reg, row_bytes_next;
    logic [PLANE_CNT_W-1:0]    plane_count_reg, plane_count_next;
    logic [ROW_CNT_W-1:0]      row_count_reg, row_count_next;

    logic [MAX_ROW_BYTES-1:0]  valid_reg, valid_next;
    logic                      rd_valid_reg, rd_valid_next;
    logic [BUF_W-1:0]          rd_data_reg;
    logic [BUF_W-1:0]          line_mem [MAX_ROW_BYTES];

    logic                      out_valid_reg, out_valid_next;
    logic [PIXELS_W-1:0]       pixels_reg, pixels_next;
    logic [COLUMN_W-1:0]       column_reg, column_next;
    logic [ROW_OUT_W-1:0]      row_out_reg, row_out_next;
    logic                      last_reg, last_next;
    logic                      row_end_reg, row_end_next;
    logic                      image_end_reg, image_end_next;

    logic [RB_W-1:0]           rb_eff;
    logic [PLANE_CNT_W-1:0]    pc_eff;
    logic [ROW_CNT_W-1:0]      rows_eff;
    logic                      line_end, last_plane, last_row;
    logic                      slot_free, mem_we, finish;
    logic [LEFT_W-1:0]         bl_dec;
    logic [BUF_W-1:0]          old_word, merged;
    logic [PIXELS_W-1:0]       chunky;

    // clamped register values
    always_comb
    begin
        if (row_bytes_reg == '0)
            rb_eff = RB_W'(1);
        else if (RB_W'(row_bytes_reg) > RB_W'(MAX_ROW_BYTES))
            rb_eff = RB_W'(MAX_ROW_BYTES);
        else
            rb_eff = RB_W'(row_bytes_reg);

        if (plane_count_reg == '0)
            pc_eff = PLANE_CNT_W'(1);
        else if (plane_count_reg > PLANE_CNT_W'(MAX_PLANES))
            pc_eff = PLANE_CNT_W'(MAX_PLANES);
        else
            pc_eff = plane_count_reg;

        if (row_count_reg == '0)
            rows_eff = ROW_CNT_W'(1);
        else if (row_count_reg > ROW_CNT_W'(ROW_CAP))
            rows_eff = ROW_CNT_W'(ROW_CAP);
        else
            rows_eff = row_count_reg;
    end

    assign line_end   = (RB_W'(column_pos_reg) + RB_W'(1)) >= rb_eff;
    assign last_plane = (PLANE_CNT_W'(plane_pos_reg) + PLANE_CNT_W'(1)) >= pc_eff;
    assign last_row   = (ROW_CNT_W'(row_pos_reg) + ROW_CNT_W'(1)) >= rows_eff;
    assign slot_free  = !out_valid_reg || out_ready;
    assign bl_dec     = (bytes_left_reg != '0) ? bytes_left_reg - LEFT_W'(1) : '0;
    assign old_word   = rd_valid_reg ? rd_data_reg : '0;

    // byte merge and planar to chunky turn
    always_comb
    begin
        merged = old_word;
        chunky = '0;
        for (int k = 0; k < MAX_PLANES; k++)
        begin
            if (PLANE_W'(k) == plane_pos_reg)
                merged[BYTE_W*k +: BYTE_W] = put_byte_reg;
        end
        for (int k = 0; k < MAX_PLANES; k++)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (PLANE_CNT_W'(k) < pc_eff)
                    chunky[8*i + k] = merged[BYTE_W*k + 7 - i];
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        mode_next        = mode_reg;
        bytes_left_next  = bytes_left_reg;
        put_byte_next    = put_byte_reg;
        column_pos_next  = column_pos_reg;
        plane_pos_next   = plane_pos_reg;
        row_pos_next     = row_pos_reg;
        compressed_next  = compressed_reg;
        row_bytes_next   = row_bytes_reg;
        plane_count_next = plane_count_reg;
        row_count_next   = row_count_reg;
        valid_next       = valid_reg;
        out_valid_next   = out_valid_reg;
        pixels_next      = pixels_reg;
        column_next      = column_reg;
        row_out_next     = row_out_reg;
        last_next        = last_reg;
        row_end_next     = row_end_reg;
        image_end_next   = image_end_reg;
        mem_we           = 1'b0;
        finish           = 1'b0;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_COMPRESSED:  compressed_next  = cfg_data[0];
                CFG_ROW_BYTES:   row_bytes_next   = cfg_data[ROW_BYTES_W-1:0];
                CFG_PLANE_COUNT: plane_count_next = cfg_data[PLANE_CNT_W-1:0];
                CFG_ROW_COUNT:   row_count_next   = cfg_data[ROW_CNT_W-1:0];
                default:         ;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    put_byte_next = data_byte;
                    if (!compressed_reg)
                    begin
                        phase_next      = PH_CMD;
                        bytes_left_next = '0;
                        mode_next       = M_ONE;
                        state_next      = S_PUT;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_CMD:
                            begin
                                if (data_byte < CMD_NOOP)
                                begin
                                    phase_next      = PH_LIT;
                                    bytes_left_next = data_byte + LEFT_W'(1);
                                end
                                else if (data_byte > CMD_NOOP)
                                begin
                                    phase_next      = PH_RUN;
                                    bytes_left_next = LEFT_W'(RUN_BIAS - {1'b0, data_byte});
                                end
                            end
                            PH_LIT:
                            begin
                                mode_next  = M_LIT;
                                state_next = S_PUT;
                            end
                            PH_RUN:
                            begin
                                mode_next  = M_RUN;
                                state_next = S_PUT;
                            end
                            PH_SKIP:
                            begin
                                bytes_left_next = bl_dec;
                                if (bl_dec == '0)
                                    phase_next = PH_CMD;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_PUT:
            begin
                if (!last_plane || slot_free)
                begin
                    mem_we = 1'b1;
                    valid_next[column_pos_reg] = 1'b1;
                    finish = (mode_reg != M_RUN) || (bytes_left_reg <= LEFT_W'(1))
                             || line_end;

                    if (last_plane)
                    begin
                        out_valid_next = 1'b1;
                        pixels_next    = chunky;
                        column_next    = COLUMN_W'(column_pos_reg);
                        row_out_next   = row_pos_reg;
                        last_next      = finish;
                        row_end_next   = line_end;
                        image_end_next = line_end && last_row;
                    end

                    if (!line_end)
                        column_pos_next = column_pos_reg + COL_W'(1);
                    else
                    begin
                        column_pos_next = '0;
                        if (!last_plane)
                            plane_pos_next = plane_pos_reg + PLANE_W'(1);
                        else
                        begin
                            plane_pos_next = '0;
                            row_pos_next   = last_row ? '0 : row_pos_reg + ROW_OUT_W'(1);
                        end
                    end

                    case (mode_reg)
                        M_RUN:
                        begin
                            bytes_left_next = finish ? '0 : bytes_left_reg - LEFT_W'(1);
                            if (finish)
                                phase_next = PH_CMD;
                        end
                        M_LIT:
                        begin
                            bytes_left_next = bl_dec;
                            if (bl_dec == '0)
                                phase_next = PH_CMD;
                            else if (line_end)
                                phase_next = PH_SKIP;
                        end
                        default: ;
                    endcase

                    if (finish)
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        rd_valid_next = valid_next[column_pos_next];
    end

    // line buffer, read at the next position with write bypass
    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[column_pos_reg] <= merged;
        if (mem_we && (column_pos_reg == column_pos_next))
            rd_data_reg <= merged;
        else
            rd_data_reg <= line_mem[column_pos_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_CMD;
            mode_reg        <= M_ONE;
            bytes_left_reg  <= '0;
            put_byte_reg    <= '0;
            column_pos_reg  <= '0;
            plane_pos_reg   <= '0;
            row_pos_reg     <= '0;
            compressed_reg  <= RST_COMPRESSED;
            row_bytes_reg   <= RST_ROW_BYTES;
            plane_count_reg <= RST_PLANE_COUNT;
            row_count_reg   <= RST_ROW_COUNT;
            valid_reg       <= '0;
            rd_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            pixels_reg      <= '0;
            column_reg      <= '0;
            row_out_reg     <= '0;
            last_reg        <= 1'b0;
            row_end_reg     <= 1'b0;
            image_end_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            mode_reg        <= mode_next;
            bytes_left_reg  <= bytes_left_next;
            put_byte_reg    <= put_byte_next;
            column_pos_reg  <= column_pos_next;
            plane_pos_reg   <= plane_pos_next;
            row_pos_reg     <= row_pos_next;
            compressed_reg  <= compressed_next;
            row_bytes_reg   <= row_bytes_next;
            plane_count_reg <= plane_count_next;
            row_count_reg   <= row_count_next;
            valid_reg       <= valid_next;
            rd_valid_reg    <= rd_valid_next;
            out_valid_reg   <= out_valid_next;
            pixels_reg      <= pixels_next;
            column_reg      <= column_next;
            row_out_reg     <= row_out_next;
            last_reg        <= last_next;
            row_end_reg     <= row_end_next;
            image_end_reg   <= image_end_next;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign pixels        = pixels_reg;
    assign column        = column_reg;
    assign row_index_out = row_out_reg;
    assign last_of_burst = last_reg;
    assign row_end       = row_end_reg;
    assign image_end     = image_end_reg;

    `ASSERT_ALWAYS(a_col_range, RB_W'(column_pos_reg) < RB_W'(MAX_ROW_BYTES),
                   "column position out of range")
    `ASSERT_ALWAYS(a_left_range, bytes_left_reg <= LEFT_W'(128), "byte count above 128")
    `ASSERT_IMPLIES(a_run_count, (state_reg == S_PUT) && (mode_reg == M_RUN),
                    bytes_left_reg != '0, "run step with no repeats left")
    `ASSERT_IMPLIES(a_image_end, out_valid_reg && image_end_reg, row_end_reg,
                    "image end without row end")
    `ASSERT_IMPLIES(a_write_free, mem_we && last_plane, !out_valid_reg || out_ready,
                    "result written over a waiting item")

endmodule

`default_nettype wire
